FILE: src/bgcr_pkg.sv
package bgcr_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_LOAD_LATIN    = 2'd0,
    OP_LOAD_CYRILLIC = 2'd1,
    OP_SET_CURSOR    = 2'd2,
    OP_PUT_CHAR      = 2'd3
  } bgcr_op_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATIN_HEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATIN_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CYRILLIC_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CYRILLIC_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LATIN_PRESENT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CYRILLIC_PRESENT = 3'd7;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration reset values
  localparam logic [4:0] RST_HEIGHT  = 5'd7;
  localparam logic [4:0] RST_WIDTH   = 5'd5;
  localparam logic [7:0] RST_SPACING = 8'd1;

  // Character code map
  localparam logic [7:0] CHAR_PRINT_FIRST = 8'd32;
  localparam logic [7:0] CHAR_GAP_FIRST   = 8'h80;
  localparam logic [7:0] CHAR_CYR_FIRST   = 8'hC0;
  localparam logic [7:0] GAP_ADVANCE      = 8'h01;
  localparam int unsigned BAND_SHIFT      = 3;    // 8 rows per band

  // Glyph counts of the two tables
  localparam int unsigned LATIN_GLYPHS    = 96;
  localparam int unsigned CYRILLIC_GLYPHS = 64;

  // Default sizing
  localparam int unsigned MAX_WIDTH_DEF = 16;
  localparam int unsigned MAX_BANDS_DEF = 3;
  localparam int unsigned LATIN_DEPTH_DEF =
      LATIN_GLYPHS * (MAX_BANDS_DEF * MAX_WIDTH_DEF + 1);

  // Input item
  typedef struct packed {
    bgcr_op_e    op;
    logic [12:0] mem_addr;
    logic [7:0]  mem_data;
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } bgcr_in_t;

  // Result item
  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] band_y;
    logic [7:0]  pattern;
    logic [7:0]  write_mask;
    logic        last;
  } bgcr_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic calc_stride;
    logic calc_base;
    logic rd_width;
    logic chk_width;
    logic issue;
  } bgcr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic put_draw;
    logic width_ok;
    logic final_band;
    logic out_free;
  } bgcr_sts_t;

endpackage

FILE: src/bgcr_glyph_mem.sv
module bgcr_glyph_mem import bgcr_pkg::*; #(
  parameter int unsigned DEPTH = LATIN_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Byte-wide store, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bgcr_dp.sv
module bgcr_dp import bgcr_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned MAX_BANDS = MAX_BANDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bgcr_cmd_t            cmd_i,
  output bgcr_sts_t            sts_o,
  input  bgcr_in_t             in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output bgcr_out_t            out_data_o
);

  localparam int unsigned STRIDE_MAX = MAX_BANDS * MAX_WIDTH + 1;
  localparam int unsigned LAT_DEPTH  = LATIN_GLYPHS * STRIDE_MAX;
  localparam int unsigned CYR_DEPTH  = CYRILLIC_GLYPHS * STRIDE_MAX;
  localparam int unsigned LAW = $clog2(LAT_DEPTH);
  localparam int unsigned CAW = $clog2(CYR_DEPTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned BW  = $clog2(MAX_BANDS + 1);
  localparam int unsigned SW  = $clog2(STRIDE_MAX + 1);

  // Configuration registers
  logic [4:0] lat_h_q, lat_w_q, cyr_h_q, cyr_w_q;
  logic [7:0] spacing_q;
  logic       transp_q, lat_pres_q, cyr_pres_q;

  // Cursor and output stage control
  logic [15:0] cx_q, cy_q;
  logic        out_valid_q;

  // Per-character working registers
  logic           tbl_sel_q;   // 1 selects the Cyrillic table
  logic [6:0]     idx_q;
  logic [BW-1:0]  bands_q;
  logic [WW-1:0]  maxw_q;
  logic [SW-1:0]  stride_q;
  logic [LAW-1:0] base_q, addr_q;
  logic [WW-1:0]  w_q, col_q;
  logic [BW-1:0]  band_q;

  // Output payload
  logic [15:0] px_q, by_q;
  logic        last_q, out_sel_q;

  logic [7:0] lat_rd, cyr_rd, rd_byte, pattern;
  logic       is_put, lat_rng, cyr_rng, gap_rng;
  logic       lat_we, cyr_we, rd_en;
  logic [LAW-1:0] raddr;
  logic [2:0] bands_raw;
  logic [5:0] maxw_raw;
  logic [4:0] sel_h, sel_w;
  logic       band_wrap, final_band, out_free;

  // Input decode
  assign is_put  = (in_data_i.op == OP_PUT_CHAR);
  assign lat_rng = in_data_i.char_code inside {[CHAR_PRINT_FIRST : CHAR_GAP_FIRST - 8'd1]};
  assign gap_rng = in_data_i.char_code inside {[CHAR_GAP_FIRST : CHAR_CYR_FIRST - 8'd1]};
  assign cyr_rng = in_data_i.char_code inside {[CHAR_CYR_FIRST : 8'hFF]};

  // Raw band count and width of the addressed table, saturated when latched
  assign sel_h     = cyr_rng ? cyr_h_q : lat_h_q;
  assign sel_w     = cyr_rng ? cyr_w_q : lat_w_q;
  assign bands_raw = 3'(sel_h[4:3]) + 3'd1;
  assign maxw_raw  = 6'(sel_w);

  // Glyph loads, out-of-depth writes dropped
  assign lat_we = cmd_i.accept && (in_data_i.op == OP_LOAD_LATIN)
                  && (32'(in_data_i.mem_addr) < LAT_DEPTH);
  assign cyr_we = cmd_i.accept && (in_data_i.op == OP_LOAD_CYRILLIC)
                  && (32'(in_data_i.mem_addr) < CYR_DEPTH);

  // Read side: width byte at the glyph base, then one band per issue
  assign rd_en = cmd_i.rd_width || cmd_i.issue;
  assign raddr = cmd_i.rd_width ? base_q : addr_q;

  bgcr_glyph_mem #(.DEPTH(LAT_DEPTH)) u_lat_mem (
    .clk_i   (clk_i),
    .we_i    (lat_we),
    .waddr_i (LAW'(in_data_i.mem_addr)),
    .wdata_i (in_data_i.mem_data),
    .re_i    (rd_en && !tbl_sel_q),
    .raddr_i (raddr),
    .rdata_o (lat_rd)
  );

  bgcr_glyph_mem #(.DEPTH(CYR_DEPTH)) u_cyr_mem (
    .clk_i   (clk_i),
    .we_i    (cyr_we),
    .waddr_i (CAW'(in_data_i.mem_addr)),
    .wdata_i (in_data_i.mem_data),
    .re_i    (rd_en && tbl_sel_q),
    .raddr_i (CAW'(raddr)),
    .rdata_o (cyr_rd)
  );

  assign rd_byte = tbl_sel_q ? cyr_rd : lat_rd;

  // Position tracking
  assign band_wrap  = (BW'(band_q + 1'b1) == bands_q);
  assign final_band = band_wrap && (WW'(col_q + 1'b1) == w_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Status to controller
  always_comb begin
    sts_o.put_draw   = is_put && ((lat_rng && lat_pres_q) || (cyr_rng && cyr_pres_q));
    sts_o.width_ok   = (rd_byte != 8'd0) && (rd_byte <= 8'(maxw_q));
    sts_o.final_band = final_band;
    sts_o.out_free   = out_free;
  end

  // Configuration, cursor and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_h_q     <= RST_HEIGHT;
      lat_w_q     <= RST_WIDTH;
      cyr_h_q     <= RST_HEIGHT;
      cyr_w_q     <= RST_WIDTH;
      spacing_q   <= RST_SPACING;
      transp_q    <= 1'b0;
      lat_pres_q  <= 1'b0;
      cyr_pres_q  <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LATIN_HEIGHT:     lat_h_q    <= cfg_data_i[4:0];
          CFG_LATIN_WIDTH:      lat_w_q    <= cfg_data_i[4:0];
          CFG_CYRILLIC_HEIGHT:  cyr_h_q    <= cfg_data_i[4:0];
          CFG_CYRILLIC_WIDTH:   cyr_w_q    <= cfg_data_i[4:0];
          CFG_SPACING:          spacing_q  <= cfg_data_i;
          CFG_TRANSPARENT:      transp_q   <= cfg_data_i[0];
          CFG_LATIN_PRESENT:    lat_pres_q <= cfg_data_i[0];
          CFG_CYRILLIC_PRESENT: cyr_pres_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      // Cursor moves: set, undrawn gap code, rejected width, end of glyph
      if (cmd_i.accept && (in_data_i.op == OP_SET_CURSOR)) begin
        cx_q <= in_data_i.pos_x;
        cy_q <= in_data_i.pos_y;
      end else if (cmd_i.accept && is_put && gap_rng) begin
        cx_q <= 16'(cx_q + 16'(GAP_ADVANCE) + 16'(spacing_q));
      end else if (cmd_i.chk_width && !sts_o.width_ok) begin
        cx_q <= 16'(cx_q + 16'(spacing_q));
      end else if (cmd_i.issue && final_band) begin
        cx_q <= 16'(cx_q + 16'(w_q) + 16'(spacing_q));
      end

      if (out_free) begin
        out_valid_q <= cmd_i.issue;
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_put) begin
      tbl_sel_q <= cyr_rng;
      idx_q     <= cyr_rng ? 7'(in_data_i.char_code - CHAR_CYR_FIRST)
                           : 7'(in_data_i.char_code - CHAR_PRINT_FIRST);
      bands_q   <= (bands_raw > 3'(MAX_BANDS)) ? BW'(MAX_BANDS) : BW'(bands_raw);
      maxw_q    <= (maxw_raw > 6'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(maxw_raw);
    end
    if (cmd_i.calc_stride) begin
      stride_q <= SW'(SW'(bands_q) * SW'(maxw_q) + SW'(1));
    end
    if (cmd_i.calc_base) begin
      base_q <= LAW'(LAW'(idx_q) * LAW'(stride_q));
    end
    if (cmd_i.chk_width) begin
      w_q    <= WW'(rd_byte);
      col_q  <= '0;
      band_q <= '0;
      addr_q <= LAW'(base_q + 1'b1);
    end
    if (cmd_i.issue) begin
      px_q      <= 16'(cx_q + 16'(col_q));
      by_q      <= 16'(cy_q + (16'(band_q) << BAND_SHIFT));
      last_q    <= final_band;
      out_sel_q <= tbl_sel_q;
      addr_q    <= LAW'(addr_q + 1'b1);
      if (band_wrap) begin
        band_q <= '0;
        col_q  <= WW'(col_q + 1'b1);
      end else begin
        band_q <= BW'(band_q + 1'b1);
      end
    end
  end

  // Result item
  assign pattern     = out_sel_q ? cyr_rd : lat_rd;
  assign out_valid_o = out_valid_q;
  always_comb begin
    out_data_o.pixel_x    = px_q;
    out_data_o.band_y     = by_q;
    out_data_o.pattern    = pattern;
    out_data_o.write_mask = transp_q ? pattern : 8'hFF;
    out_data_o.last       = last_q;
  end

  // A band read must never overwrite a result still waiting
  a_issue_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> out_free)
    else $error("band issued while output stage is occupied");

  // Width fetch leaves the output stage empty
  a_width_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_width |=> !out_valid_q)
    else $error("width byte presented as a result");

  // Column counter stays inside the accepted glyph width
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (col_q < w_q))
    else $error("column index beyond glyph width");

endmodule

FILE: src/bgcr_ctrl.sv
module bgcr_ctrl import bgcr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  bgcr_sts_t sts_i,
  output bgcr_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STRIDE = 3'd1;
  localparam logic [2:0] S_BASE   = 3'd2;
  localparam logic [2:0] S_RDW    = 3'd3;
  localparam logic [2:0] S_WCHK   = 3'd4;
  localparam logic [2:0] S_RUN    = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Input acceptance and sequencing of one put-character transaction
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.put_draw) begin
          state_d = S_STRIDE;
        end
      end
      S_STRIDE: begin
        cmd_o.calc_stride = 1'b1;
        state_d           = S_BASE;
      end
      S_BASE: begin
        cmd_o.calc_base = 1'b1;
        state_d         = S_RDW;
      end
      S_RDW: begin
        if (sts_i.out_free) begin
          cmd_o.rd_width = 1'b1;
          state_d        = S_WCHK;
        end
      end
      S_WCHK: begin
        cmd_o.chk_width = 1'b1;
        state_d         = sts_i.width_ok ? S_RUN : S_IDLE;
      end
      S_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.issue = 1'b1;
          if (sts_i.final_band) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Last band returns the sequencer to idle
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && sts_i.final_band) |=> (state_q == S_IDLE))
    else $error("sequencer did not finish after final band");

  // Rejected width ends the transaction without a band
  a_reject_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.chk_width && !sts_i.width_ok) |=> (state_q == S_IDLE))
    else $error("rejected glyph width did not end the character");

endmodule

FILE: src/bitmap_glyph_column_renderer.sv
// A put-character transaction computes the stride and glyph base, reads and checks the width
// byte, then issues bands: one band a cycle from the glyph memory read port while the output
// is not stalled; a rejected width ends the transaction without a band. Loads, cursor moves
// and undrawn codes do not stall the input.
// Reset: configuration returns to its defaults, cursor to zero; glyph memories are
// not cleared and hold unknown data until loaded. No clearing pass after reset.
module bitmap_glyph_column_renderer import bgcr_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned MAX_BANDS = MAX_BANDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bgcr_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bgcr_out_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  bgcr_cmd_t cmd;
  bgcr_sts_t sts;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  bgcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bgcr_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BANDS (MAX_BANDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/sv/bitmap_glyph_column_renderer_tb.sv
`timescale 1ns / 100ps

module bitmap_glyph_column_renderer_tb;
  import bgcr_pkg::*;

  localparam int unsigned LAT_DEPTH    = LATIN_DEPTH_DEF;
  localparam int unsigned CYR_DEPTH    =
      CYRILLIC_GLYPHS * (MAX_BANDS_DEF * MAX_WIDTH_DEF + 1);
  localparam int          PREDICTED    = -1;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned PHASE_ITEMS  = 26;
  localparam int          TIMEOUT_NS   = 20_000_000;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  // One line of the directed sequence
  typedef struct {
    row_kind_e            kind;
    bgcr_in_t             item;
    int                   n_typed;
    bgcr_out_t            typed [2];
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [7:0]           reg_val;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  bgcr_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  bgcr_out_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow of the glyph memories, cursor and registers
  logic [7:0]  lat_mem [LAT_DEPTH];
  logic [7:0]  cyr_mem [CYR_DEPTH];
  bit          lat_wr [LAT_DEPTH];
  bit          cyr_wr [CYR_DEPTH];
  logic [15:0] cur_x, cur_y;
  logic [4:0]  lat_h, lat_w, cyr_h, cyr_w;
  logic [7:0]  spacing;
  logic        transp, lat_on, cyr_on;

  bgcr_out_t   exp_bands [$];
  bgcr_out_t   band_exp;
  dir_row_t    dir_rows [$];

  int unsigned n_items, n_bands, n_reg_writes, n_fail, stall_left;
  bit          quiet;

  bitmap_glyph_column_renderer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // Band count and maximum width after saturation
  function automatic int unsigned glyph_bands(input bit cyr);
    int unsigned b;
    b = ((cyr ? cyr_h : lat_h) >> BAND_SHIFT) + 1;
    return (b > MAX_BANDS_DEF) ? MAX_BANDS_DEF : b;
  endfunction

  function automatic int unsigned glyph_width(input bit cyr);
    int unsigned w;
    w = cyr ? cyr_w : lat_w;
    return (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
  endfunction

  function automatic int unsigned glyph_base(input bit cyr, input logic [7:0] code);
    int unsigned idx;
    idx = cyr ? code - CHAR_CYR_FIRST : code - CHAR_PRINT_FIRST;
    return idx * (glyph_bands(cyr) * glyph_width(cyr) + 1);
  endfunction

  function automatic logic [7:0] glyph_byte(input bit cyr, input int unsigned a);
    if (cyr) return (a < CYR_DEPTH) ? cyr_mem[a] : 8'h00;
    return (a < LAT_DEPTH) ? lat_mem[a] : 8'h00;
  endfunction

  function automatic bit byte_written(input bit cyr, input int unsigned a);
    if (cyr) return (a < CYR_DEPTH) ? cyr_wr[a] : 1'b0;
    return (a < LAT_DEPTH) ? lat_wr[a] : 1'b0;
  endfunction

  // A put-character is only sent when every byte it reads has been loaded
  function automatic bit reads_ok(input logic [7:0] code);
    bit          cyr;
    int unsigned base, w, nb;
    if (code < CHAR_PRINT_FIRST) return 1'b1;
    if (code >= CHAR_GAP_FIRST && code < CHAR_CYR_FIRST) return 1'b1;
    cyr = (code >= CHAR_CYR_FIRST);
    if (!(cyr ? cyr_on : lat_on)) return 1'b1;
    base = glyph_base(cyr, code);
    if (!byte_written(cyr, base)) return 1'b0;
    w = glyph_byte(cyr, base);
    if (w == 0 || w > glyph_width(cyr)) return 1'b1;
    nb = glyph_bands(cyr);
    for (int unsigned a = base + 1; a <= base + w * nb; a++) begin
      if (!byte_written(cyr, a)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected bands of one transaction; keep = 0 only updates the shadow state
  function automatic void predict_bands(input bgcr_in_t it, input bit keep);
    bit          cyr;
    int unsigned nb, mw, base, w;
    bgcr_out_t   b;
    case (it.op)
      OP_LOAD_LATIN: begin
        if (it.mem_addr < LAT_DEPTH) begin
          lat_mem[it.mem_addr] = it.mem_data;
          lat_wr[it.mem_addr]  = 1'b1;
        end
      end
      OP_LOAD_CYRILLIC: begin
        if (it.mem_addr < CYR_DEPTH) begin
          cyr_mem[it.mem_addr] = it.mem_data;
          cyr_wr[it.mem_addr]  = 1'b1;
        end
      end
      OP_SET_CURSOR: begin
        cur_x = it.pos_x;
        cur_y = it.pos_y;
      end
      default: begin
        if (it.char_code < CHAR_PRINT_FIRST) return;
        // codes between the two tables just move the cursor
        if (it.char_code >= CHAR_GAP_FIRST && it.char_code < CHAR_CYR_FIRST) begin
          cur_x = cur_x + 16'(GAP_ADVANCE) + 16'(spacing);
          return;
        end
        cyr = (it.char_code >= CHAR_CYR_FIRST);
        if (!(cyr ? cyr_on : lat_on)) return;
        nb   = glyph_bands(cyr);
        mw   = glyph_width(cyr);
        base = glyph_base(cyr, it.char_code);
        w    = glyph_byte(cyr, base);
        if (w > mw) begin
          cur_x = cur_x + 16'(spacing);
          return;
        end
        // column-major walk over the glyph
        for (int unsigned i = 0; i < w; i++) begin
          for (int unsigned j = 0; j < nb; j++) begin
            b.pixel_x    = cur_x + 16'(i);
            b.band_y     = cur_y + 16'(j << BAND_SHIFT);
            b.pattern    = glyph_byte(cyr, base + 1 + i * nb + j);
            b.write_mask = transp ? b.pattern : 8'hFF;
            b.last       = (i + 1 == w) && (j + 1 == nb);
            if (keep) exp_bands.push_back(b);
          end
        end
        cur_x = cur_x + 16'(w) + 16'(spacing);
      end
    endcase
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    case (idx)
      CFG_LATIN_HEIGHT:     lat_h   = val[4:0];
      CFG_LATIN_WIDTH:      lat_w   = val[4:0];
      CFG_CYRILLIC_HEIGHT:  cyr_h   = val[4:0];
      CFG_CYRILLIC_WIDTH:   cyr_w   = val[4:0];
      CFG_SPACING:          spacing = val;
      CFG_TRANSPARENT:      transp  = val[0];
      CFG_LATIN_PRESENT:    lat_on  = val[0];
      CFG_CYRILLIC_PRESENT: cyr_on  = val[0];
      default: ;
    endcase
  endfunction

  // Register values biased towards the edges of each range
  function automatic logic [7:0] pick_reg_val(input logic [CFG_IDX_W-1:0] idx);
    int unsigned k;
    k = $urandom_range(0, 5);
    case (idx)
      CFG_LATIN_HEIGHT, CFG_CYRILLIC_HEIGHT: begin
        case (k)
          0: return 8'd0;
          1: return 8'd7;
          2: return 8'd15;
          3: return 8'd23;
          4: return 8'hFF;
          default: return 8'($urandom_range(0, 23));
        endcase
      end
      CFG_LATIN_WIDTH, CFG_CYRILLIC_WIDTH: begin
        case (k)
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd16;
          3: return 8'hFF;
          default: return 8'($urandom_range(2, 16));
        endcase
      end
      CFG_SPACING: begin
        case (k)
          0: return 8'd0;
          1: return 8'hFF;
          default: return 8'($urandom);
        endcase
      end
      CFG_TRANSPARENT: return 8'($urandom);
      default: return {7'($urandom), 1'(k != 0)};
    endcase
  endfunction

  function automatic bgcr_in_t rand_item();
    bgcr_in_t it;
    it.op        = bgcr_op_e'(2'($urandom_range(0, 3)));
    it.mem_addr  = 13'($urandom);
    it.mem_data  = 8'($urandom);
    it.char_code = 8'($urandom);
    it.pos_x     = 16'($urandom);
    it.pos_y     = 16'($urandom);
    return it;
  endfunction

  // Directed row builders
  function automatic void item_row(input bgcr_op_e op, input int unsigned addr,
                                   input int unsigned data, input int unsigned code,
                                   input int n_typed);
    dir_row_t r;
    r.kind           = ROW_ITEM;
    r.item           = rand_item();
    r.item.op        = op;
    r.item.mem_addr  = 13'(addr);
    r.item.mem_data  = 8'(data);
    r.item.char_code = 8'(code);
    r.n_typed        = n_typed;
    dir_rows.push_back(r);
  endfunction

  // Random bytes over a run of glyph memory addresses
  function automatic void fill_rows(input bgcr_op_e op, input int unsigned first,
                                    input int unsigned count);
    for (int unsigned a = first; a < first + count; a++) begin
      item_row(op, a, $urandom_range(0, 255), 0, 0);
    end
  endfunction

  function automatic void cursor_row(input int unsigned x, input int unsigned y);
    item_row(OP_SET_CURSOR, 0, 0, 0, 0);
    dir_rows[dir_rows.size()-1].item.pos_x = 16'(x);
    dir_rows[dir_rows.size()-1].item.pos_y = 16'(y);
  endfunction

  function automatic void band_row(input logic [15:0] x, input logic [15:0] y,
                                   input logic [7:0] pat, input logic [7:0] mask,
                                   input logic lst);
    int unsigned k, n;
    k = dir_rows.size() - 1;
    n = dir_rows[k].n_typed;
    dir_rows[k].typed[n] = '{pixel_x: x, band_y: y, pattern: pat, write_mask: mask, last: lst};
    dir_rows[k].n_typed  = n + 1;
  endfunction

  function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    dir_row_t r;
    r.kind    = ROW_REG;
    r.item    = '0;
    r.n_typed = 0;
    r.reg_idx = idx;
    r.reg_val = val;
    dir_rows.push_back(r);
  endfunction

  // Input side: optional idle burst, then hold the transaction until taken
  task automatic send_item(input bgcr_in_t it, input bit keep);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_bands(it, keep);
    n_items++;
  endtask

  // Stop sending, let every expected band drain, then allow for trailing work
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (exp_bands.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Keeps cfg_valid_i high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    n_reg_writes++;
  endtask

  task automatic program_phase(input bit all_regs);
    logic [CFG_IDX_W-1:0] ri;
    wait_idle();
    for (int r = 0; r < 8; r++) begin
      ri = r[CFG_IDX_W-1:0];
      if (all_regs || $urandom_range(0, 1)) write_reg(ri, pick_reg_val(ri));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // One character: plant a width byte (at times zero or too wide) and its columns, then draw
  task automatic put_glyph_sequence();
    bit          cyr;
    logic [7:0]  code;
    int unsigned base, mw, nb, wb, r;
    bgcr_in_t    it;
    cyr  = $urandom_range(0, 1);
    code = cyr ? 8'(CHAR_CYR_FIRST + $urandom_range(0, CYRILLIC_GLYPHS - 1))
               : 8'(CHAR_PRINT_FIRST + $urandom_range(0, LATIN_GLYPHS - 1));
    base = glyph_base(cyr, code);
    mw   = glyph_width(cyr);
    nb   = glyph_bands(cyr);
    r    = $urandom_range(0, 9);
    if (r == 0 || (mw == 0 && r != 1)) wb = 0;
    else if (r == 1) wb = $urandom_range(mw + 1, 255);
    else if (r == 2) wb = mw;
    else wb = $urandom_range(1, (mw < 3) ? mw : 3);

    it          = rand_item();
    it.op       = cyr ? OP_LOAD_CYRILLIC : OP_LOAD_LATIN;
    it.mem_addr = 13'(base);
    it.mem_data = 8'(wb);
    send_item(it, 1'b1);

    // every column byte the draw reads is loaded; some are reloaded
    if (wb > 0 && wb <= mw) begin
      for (int unsigned a = base + 1; a <= base + wb * nb; a++) begin
        if (!byte_written(cyr, a) || $urandom_range(0, 7) == 0) begin
          it.mem_addr = 13'(a);
          it.mem_data = 8'($urandom);
          send_item(it, 1'b1);
        end
      end
    end

    if ($urandom_range(0, 2) == 0) begin
      it    = rand_item();
      it.op = OP_SET_CURSOR;
      send_item(it, 1'b1);
    end

    repeat ($urandom_range(1, 2)) begin
      it           = rand_item();
      it.op        = OP_PUT_CHAR;
      it.char_code = code;
      send_item(it, 1'b1);
    end
  endtask

  // Output side: check each band taken, and drive random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_bands.size() == 0) begin
        $error("band with nothing expected: x %h y %h pattern %h",
               out_data_o.pixel_x, out_data_o.band_y, out_data_o.pattern);
        n_fail++;
      end else begin
        band_exp = exp_bands.pop_front();
        n_bands++;
        if (out_data_o.pixel_x !== band_exp.pixel_x) begin
          $error("pixel_x: expected %h, got %h", band_exp.pixel_x, out_data_o.pixel_x);
          n_fail++;
        end
        if (out_data_o.band_y !== band_exp.band_y) begin
          $error("band_y: expected %h, got %h", band_exp.band_y, out_data_o.band_y);
          n_fail++;
        end
        if (out_data_o.pattern !== band_exp.pattern) begin
          $error("pattern: expected %h, got %h", band_exp.pattern, out_data_o.pattern);
          n_fail++;
        end
        if (out_data_o.write_mask !== band_exp.write_mask) begin
          $error("write_mask: expected %h, got %h",
                 band_exp.write_mask, out_data_o.write_mask);
          n_fail++;
        end
        if (out_data_o.last !== band_exp.last) begin
          $error("last: expected %b, got %b", band_exp.last, out_data_o.last);
          n_fail++;
        end
      end
    end

    if (quiet) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    bgcr_in_t    it;
    int unsigned phase_end;
    bit          held;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    held = 1'b0;
    quiet = 1'b0;

    // shadow state as it stands after reset
    cur_x   = '0;
    cur_y   = '0;
    lat_h   = RST_HEIGHT;
    lat_w   = RST_WIDTH;
    cyr_h   = RST_HEIGHT;
    cyr_w   = RST_WIDTH;
    spacing = RST_SPACING;
    transp  = 1'b0;
    lat_on  = 1'b0;
    cyr_on  = 1'b0;

    // Directed sequence, starting from reset defaults (stride 6, one band)
    item_row(OP_PUT_CHAR, 0, 0, 8'h41, 0);          // Latin table missing
    item_row(OP_PUT_CHAR, 0, 0, 8'hC0, 0);          // Cyrillic table missing
    item_row(OP_PUT_CHAR, 0, 0, 8'h00, 0);          // control code
    item_row(OP_PUT_CHAR, 0, 0, 8'h80, 0);          // gap codes only advance
    item_row(OP_PUT_CHAR, 0, 0, 8'hBF, 0);
    item_row(OP_LOAD_LATIN, 8191, 8'hFF, 0, 0);     // beyond depth, dropped
    item_row(OP_LOAD_CYRILLIC, CYR_DEPTH, 8'h00, 0, 0);
    reg_row(CFG_LATIN_PRESENT, 8'h01);
    item_row(OP_LOAD_LATIN, 0, 2, 0, 0);
    item_row(OP_LOAD_LATIN, 1, 8'hA5, 0, 0);
    item_row(OP_LOAD_LATIN, 2, 8'h5A, 0, 0);
    cursor_row(16'hFFFF, 16'hFFF8);
    item_row(OP_PUT_CHAR, 0, 0, 8'h20, 0);          // two columns, x wraps
    band_row(16'hFFFF, 16'hFFF8, 8'hA5, 8'hFF, 1'b0);
    band_row(16'h0000, 16'hFFF8, 8'h5A, 8'hFF, 1'b1);
    item_row(OP_LOAD_LATIN, 6, 8'hFF, 0, 0);
    item_row(OP_PUT_CHAR, 0, 0, 8'h21, 0);          // too wide
    item_row(OP_LOAD_LATIN, 12, 8'h00, 0, 0);
    item_row(OP_PUT_CHAR, 0, 0, 8'h22, 0);          // zero width
    reg_row(CFG_TRANSPARENT, 8'h01);
    reg_row(CFG_LATIN_HEIGHT, 8'hFF);               // saturates at three bands
    reg_row(CFG_LATIN_WIDTH, 8'hFF);                // saturates at full width
    item_row(OP_LOAD_LATIN, (LATIN_GLYPHS - 1) * 49, MAX_WIDTH_DEF, 0, 0);
    fill_rows(OP_LOAD_LATIN, (LATIN_GLYPHS - 1) * 49 + 1, 48);
    item_row(OP_PUT_CHAR, 0, 0, 8'h7F, PREDICTED);  // largest glyph, last slot
    reg_row(CFG_CYRILLIC_PRESENT, 8'h01);
    reg_row(CFG_CYRILLIC_HEIGHT, 8'h00);
    reg_row(CFG_CYRILLIC_WIDTH, 8'd16);
    item_row(OP_LOAD_CYRILLIC, (CYRILLIC_GLYPHS - 1) * 17, 17, 0, 0);
    item_row(OP_PUT_CHAR, 0, 0, 8'hFF, 0);          // one over the maximum
    item_row(OP_LOAD_CYRILLIC, 0, 16, 0, 0);
    fill_rows(OP_LOAD_CYRILLIC, 1, 16);
    item_row(OP_PUT_CHAR, 0, 0, 8'hC0, PREDICTED);
    reg_row(CFG_CYRILLIC_WIDTH, 8'h00);
    item_row(OP_LOAD_CYRILLIC, 1, 0, 0, 0);
    item_row(OP_PUT_CHAR, 0, 0, 8'hC1, 0);          // zero width at stride one
    reg_row(CFG_SPACING, 8'hFF);
    item_row(OP_PUT_CHAR, 0, 0, 8'h90, 0);
    reg_row(CFG_CYRILLIC_HEIGHT, 8'd23);
    reg_row(CFG_SPACING, 8'h00);
    cursor_row(0, 0);
    fill_rows(OP_LOAD_LATIN, 3, 3);                 // rest of the first glyph at stride 49
    item_row(OP_PUT_CHAR, 0, 0, 8'h20, PREDICTED);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
        cfg_valid_i <= 1'b0;
      end else begin
        send_item(dir_rows[k].item, dir_rows[k].n_typed == PREDICTED);
        for (int t = 0; t < dir_rows[k].n_typed; t++) exp_bands.push_back(dir_rows[k].typed[t]);
      end
    end

    // Random phases, each after random register writes (every register in the first); the last has no idling
    for (int ph = 0; ph < N_PHASES; ph++) begin
      program_phase(ph == 0);
      quiet     = (ph == N_PHASES - 1);
      phase_end = n_items + PHASE_ITEMS;
      while (n_items < phase_end) begin
        if ($urandom_range(0, 3) != 0) begin
          put_glyph_sequence();
        end else begin
          it = rand_item();
          // a draw over bytes never loaded becomes a code that reads nothing
          if (it.op == OP_PUT_CHAR && !reads_ok(it.char_code)) begin
            it.char_code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                : 8'(CHAR_GAP_FIRST + $urandom_range(0, 63));
          end
          send_item(it, 1'b1);
        end
        // hold off once in the third phase until the output side has caught up
        if (ph == 2 && !held) begin
          wait_idle();
          held = 1'b1;
        end
      end
    end

    wait_idle();
    $display("Covered %0d input transactions and %0d register writes; %0d bands checked.",
             n_items, n_reg_writes, n_bands);
    $display("Directed rows: %0d, random phases: %0d, the last without idling.",
             dir_rows.size(), N_PHASES);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
src/bgcr_pkg.sv
src/bgcr_glyph_mem.sv
src/bgcr_dp.sv
src/bgcr_ctrl.sv
src/bitmap_glyph_column_renderer.sv
tb/sv/bitmap_glyph_column_renderer_tb.sv
